@@ sv/broadcast_duplicate_filter_aging_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the broadcast duplicate filter.
// The macros compile to concurrent assertions in simulation and vanish
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BROADCAST_DUPLICATE_FILTER_AGING_MACROS_SVH
`define BROADCAST_DUPLICATE_FILTER_AGING_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define BDFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("broadcast duplicate filter assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("broadcast duplicate filter assertion failed");

`else

`define BDFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BDFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/bdfa_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdfa_pkg: shared constants of the broadcast duplicate filter
// Table size, derived widths, reset value of the age limit and item kinds.
// ---------------------------------------------------------------------------
package bdfa_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int OUT_CNT_W = 11;

    localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd100;

    localparam logic KIND_CHECK = 1'b0;
    localparam logic KIND_SWEEP = 1'b1;

endpackage

@@ sv/broadcast_duplicate_filter_aging.sv @@
`timescale 1ns / 1ps
// A transaction passes SCAN, which reads one entry a cycle, and FINISH, which waits for a free
// output register; a new transaction is taken only in IDLE.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to every entry of
// the valid memory, and no input transaction is taken until it ends.
// Configuration writes are taken in every cycle, also during the clearing pass.
// ---------------------------------------------------------------------------
// broadcast_duplicate_filter_aging: duplicate packet id cache with timeout
// A small sequencer scans the entry memories once per transaction with one
// shared compare unit: it looks up ids for checks and ages stamps for sweeps.
// ---------------------------------------------------------------------------
`include "broadcast_duplicate_filter_aging_macros.svh"

module broadcast_duplicate_filter_aging (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration port for the age limit.
    input  logic                                 i_cfg_wr_en,
    input  logic [bdfa_pkg::TIME_W-1:0]          i_cfg_wr_data,
    // Input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_kind,
    input  logic [bdfa_pkg::ID_W-1:0]            i_packet_id,
    input  logic [bdfa_pkg::TIME_W-1:0]          i_now_time,
    // Output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_forward,
    output logic                                 o_table_full,
    output logic [bdfa_pkg::OUT_CNT_W-1:0]       o_entries_held,
    output logic [bdfa_pkg::OUT_CNT_W-1:0]       o_entries_removed
);

    localparam int AW = bdfa_pkg::ADDR_W;
    localparam int CW = bdfa_pkg::CNT_W;

    // Sequencer states. CLEAR runs once after reset, SCAN walks the table
    // and FINISH commits the result once the output register is free.
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Entry memories. The valid memory is cleared after reset; the id and
    // stamp memories are only used where the valid bit is set.
    logic                          valid_mem [bdfa_pkg::CAPACITY];
    logic [bdfa_pkg::ID_W-1:0]     id_mem    [bdfa_pkg::CAPACITY];
    logic [bdfa_pkg::TIME_W-1:0]   stamp_mem [bdfa_pkg::CAPACITY];

    logic                          r_rd_valid;
    logic [bdfa_pkg::ID_W-1:0]     r_rd_id;
    logic [bdfa_pkg::TIME_W-1:0]   r_rd_stamp;

    logic                          vm_we;
    logic [AW-1:0]                 vm_addr;
    logic                          vm_data;
    logic                          ent_we;

    // Scan control.
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic                          r_pend, n_pend;
    logic [AW-1:0]                 r_pend_addr, n_pend_addr;
    logic                          r_hit, n_hit;
    logic                          r_have_free, n_have_free;
    logic [AW-1:0]                 r_free_slot, n_free_slot;
    logic [CW-1:0]                 r_removed, n_removed;
    logic [CW-1:0]                 r_held, n_held;

    // Captured transaction.
    logic                          r_kind, n_kind;
    logic [bdfa_pkg::ID_W-1:0]     r_pid, n_pid;
    logic [bdfa_pkg::TIME_W-1:0]   r_now, n_now;

    logic [bdfa_pkg::TIME_W-1:0]   r_age_limit;

    // Output register.
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_forward, n_out_forward;
    logic                          r_out_full, n_out_full;
    logic [bdfa_pkg::OUT_CNT_W-1:0] r_out_held, n_out_held;
    logic [bdfa_pkg::OUT_CNT_W-1:0] r_out_removed, n_out_removed;

    // Shared compare unit: age of the entry just read against the limit.
    logic [bdfa_pkg::TIME_W-1:0]   age;
    logic                          expired;
    logic                          id_match;
    logic                          out_free;
    logic                          scan_end;

    assign age      = r_now - r_rd_stamp;
    assign expired  = r_rd_valid && (age > r_age_limit);
    assign id_match = r_rd_valid && (r_rd_id == r_pid);
    assign out_free = !r_out_valid || !i_out_stall;
    assign scan_end = (r_cnt == CW'(bdfa_pkg::CAPACITY));

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_forward         = r_out_forward;
    assign o_table_full      = r_out_full;
    assign o_entries_held    = r_out_held;
    assign o_entries_removed = r_out_removed;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_pend        = r_pend;
        n_pend_addr   = r_pend_addr;
        n_hit         = r_hit;
        n_have_free   = r_have_free;
        n_free_slot   = r_free_slot;
        n_removed     = r_removed;
        n_held        = r_held;
        n_kind        = r_kind;
        n_pid         = r_pid;
        n_now         = r_now;
        n_out_valid   = r_out_valid;
        n_out_forward = r_out_forward;
        n_out_full    = r_out_full;
        n_out_held    = r_out_held;
        n_out_removed = r_out_removed;
        vm_we         = 1'b0;
        vm_addr       = r_cnt[AW-1:0];
        vm_data       = 1'b0;
        ent_we        = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                vm_we = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(bdfa_pkg::CAPACITY - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind      = i_kind;
                    n_pid       = i_packet_id;
                    n_now       = i_now_time;
                    n_cnt       = '0;
                    n_pend      = 1'b0;
                    n_hit       = 1'b0;
                    n_have_free = 1'b0;
                    n_removed   = '0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the next read while the previous entry is evaluated.
                n_pend = !scan_end;
                if (!scan_end) begin
                    n_cnt       = r_cnt + CW'(1);
                    n_pend_addr = r_cnt[AW-1:0];
                end
                if (r_pend) begin
                    if (r_kind == bdfa_pkg::KIND_CHECK) begin
                        if (id_match) begin
                            n_hit = 1'b1;
                        end
                        if (!r_rd_valid && !r_have_free) begin
                            n_have_free = 1'b1;
                            n_free_slot = r_pend_addr;
                        end
                    end else if (expired) begin
                        vm_we     = 1'b1;
                        vm_addr   = r_pend_addr;
                        vm_data   = 1'b0;
                        n_removed = r_removed + CW'(1);
                    end
                end
                if (scan_end && !r_pend) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_kind == bdfa_pkg::KIND_CHECK) begin
                        // A miss takes the lowest free slot; with no free slot
                        // the packet is still forwarded but not recorded.
                        if (!r_hit && r_have_free) begin
                            vm_we   = 1'b1;
                            vm_addr = r_free_slot;
                            vm_data = 1'b1;
                            ent_we  = 1'b1;
                            n_held  = r_held + CW'(1);
                        end
                        n_out_forward = !r_hit;
                        n_out_full    = !r_hit && !r_have_free;
                        n_out_removed = '0;
                    end else begin
                        n_held        = r_held - r_removed;
                        n_out_forward = 1'b0;
                        n_out_full    = 1'b0;
                        n_out_removed = bdfa_pkg::OUT_CNT_W'(r_removed);
                    end
                    n_out_held = bdfa_pkg::OUT_CNT_W'(n_held);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    // Memories: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            valid_mem[vm_addr] <= vm_data;
        end
        r_rd_valid <= valid_mem[r_cnt[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            id_mem[r_free_slot]    <= r_pid;
            stamp_mem[r_free_slot] <= r_now;
        end
        r_rd_id    <= id_mem[r_cnt[AW-1:0]];
        r_rd_stamp <= stamp_mem[r_cnt[AW-1:0]];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
            r_age_limit <= bdfa_pkg::AGE_LIMIT_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_age_limit <= i_cfg_wr_data;
            end
        end
    end

    // Payload and scan bookkeeping; always set before use.
    always_ff @(posedge i_clk) begin
        r_pend_addr   <= n_pend_addr;
        r_hit         <= n_hit;
        r_have_free   <= n_have_free;
        r_free_slot   <= n_free_slot;
        r_removed     <= n_removed;
        r_kind        <= n_kind;
        r_pid         <= n_pid;
        r_now         <= n_now;
        r_out_forward <= n_out_forward;
        r_out_full    <= n_out_full;
        r_out_held    <= n_out_held;
        r_out_removed <= n_out_removed;
    end

    // The number of valid entries never exceeds the table size.
    `BDFA_ASSERT_IMP(a_held_bound, i_clk, i_rst_n, 1'b1, r_held <= CW'(bdfa_pkg::CAPACITY))

    // A sweep can never remove more entries than are held.
    `BDFA_ASSERT_IMP(a_removed_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_removed <= r_held)

    // A duplicate leaves the entry count untouched.
    `BDFA_ASSERT_NXT(a_hit_keeps_count, i_clk, i_rst_n,
        r_state == ST_FINISH && out_free && r_kind == bdfa_pkg::KIND_CHECK && r_hit,
        $stable(r_held))

    // A full table is only reported for a packet that is forwarded.
    `BDFA_ASSERT_IMP(a_full_forwards, i_clk, i_rst_n, r_out_valid && r_out_full, r_out_forward)

endmodule
